### design/ffd_pkg.sv
// Shared types and constants for the fractional feedback delay.
// No dependencies; used by fractional_feedback_delay.
`default_nettype none

package ffd_pkg;

	// Default build of the delay line
	localparam int DEPTH_DEF       = 4096;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int SAMPLE_BITS_DEF = 24;

	// Feedback gain: unsigned Q1.16, unity is representable
	localparam int                 GAIN_W    = 17;
	localparam int                 GAIN_FRAC = 16;
	localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;

	// Configuration register map
	localparam int               CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_MIX,
		ST_MUL,
		ST_WB
	} ffd_state_t;

endpackage

`default_nettype wire

### design/ffd_ram.sv
// Sample store of the delay line: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new data.
`default_nettype none

module ffd_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 24,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Forward write data on an address match
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/fractional_feedback_delay.sv
// Fractional feedback delay line with linear interpolation (top level).
// Depends on ffd_pkg and ffd_ram.
//
// Each accepted input sample yields one output sample: the store is read at the write position
// minus delay_frames (FRAC_BITS fraction bits), the two neighboring entries are mixed linearly
// with round-half-up, and output * feedback_gain (Q1.16, rounded) + input is written back,
// saturated to SAMPLE_BITS. When inputs stream, a sample passes through these steps: accept
// and first tap read, second tap read, interpolation, gain multiply, then write-back in the
// cycle that accepts the next sample. The two tap reads go through the single read port of
// the sample store. A stalled output register holds the write-back cycle and with it the
// input. After reset the store is zeroed by a sweep over all DEPTH entries (4096 by default)
// during which no sample is accepted; configuration writes are taken throughout. Out-of-range
// writes (delay of zero or above DEPTH samples, gain above unity) and unknown indexes are
// dropped.
`default_nettype none

module fractional_feedback_delay #(
	parameter int DEPTH       = ffd_pkg::DEPTH_DEF,
	parameter int FRAC_BITS   = ffd_pkg::FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = ffd_pkg::SAMPLE_BITS_DEF,
	localparam int DLY_W = $clog2((longint'(DEPTH) << FRAC_BITS) + 1),
	localparam int CFG_W = (DLY_W > ffd_pkg::GAIN_W) ? DLY_W : ffd_pkg::GAIN_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed      [SAMPLE_BITS-1:0] sample_out,
	// configuration
	input  wire logic                          cfg_write_en,
	input  wire logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SB  = SAMPLE_BITS;
	localparam int PW  = AW + 1 + FRAC_BITS;
	localparam int MW  = SB + FRAC_BITS + 2;
	localparam int GPW = SB + ffd_pkg::GAIN_W + 1;
	localparam int SW  = SB + 2;

	localparam logic [DLY_W-1:0] DLY_MAX   = DLY_W'(longint'(DEPTH) << FRAC_BITS);
	localparam logic [DLY_W-1:0] DLY_RESET = DLY_W'(1) << FRAC_BITS;
	localparam logic [AW-1:0]    LAST_IDX  = AW'(DEPTH - 1);
	localparam logic [AW:0]      DEPTH_X   = (AW + 1)'(DEPTH);
	localparam logic [MW-1:0]    MIX_HALF  = MW'(1) << (FRAC_BITS - 1);
	localparam logic [GPW-1:0]   GAIN_HALF = GPW'(1) << (ffd_pkg::GAIN_FRAC - 1);

	// ---------------------------------------------------------------- registers
	ffd_pkg::ffd_state_t state_q, state_d;

	logic [DLY_W-1:0]          delay_q;
	logic [ffd_pkg::GAIN_W-1:0] gain_q;
	logic [AW-1:0]             write_pos_q;
	logic [AW-1:0]             clr_cnt_q;
	logic [AW-1:0]             i0_q;
	logic [FRAC_BITS-1:0]      frac_q;
	logic signed [SB-1:0]      x_q;
	logic signed [SB-1:0]      a_q;
	logic signed [SB-1:0]      y_q;
	logic signed [GPW-1:0]     gp_q;
	logic                      out_valid_q;
	logic signed [SB-1:0]      sample_out_q;

	// ---------------------------------------------------------------- datapath wires
	logic [AW-1:0]        wp_inc;
	logic [AW-1:0]        rd_wp;
	logic [PW-1:0]        pos;
	logic [AW:0]          idx_full;
	logic [AW-1:0]        i0_c;
	logic [FRAC_BITS-1:0] frac_c;
	logic [AW-1:0]        i1_c;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [SB-1:0]        mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [SB-1:0]        mem_rdata;

	logic signed [SB:0]        diff;
	logic signed [FRAC_BITS:0] frac_s;
	logic signed [MW-1:0]      mix_prod;
	logic signed [MW-1:0]      mix;
	logic signed [GPW-1:0]     gp_c;
	logic [GPW-1:0]            fb_round;
	logic signed [SW-1:0]      fb;
	logic signed [SW-1:0]      sum;
	logic [SB-1:0]             wb_data;

	logic                 wb_go;
	logic                 in_take;

	// ---------------------------------------------------------------- read index
	assign wp_inc = (write_pos_q == LAST_IDX) ? '0 : write_pos_q + AW'(1);
	// During write-back the next sample already belongs to the advanced position
	assign rd_wp  = (state_q == ffd_pkg::ST_WB) ? wp_inc : write_pos_q;

	always_comb begin
		pos      = {({1'b0, rd_wp} + DEPTH_X), {FRAC_BITS{1'b0}}} - PW'(delay_q);
		idx_full = pos[PW-1:FRAC_BITS];
		if (idx_full >= DEPTH_X) begin
			idx_full = idx_full - DEPTH_X;
		end
		i0_c   = idx_full[AW-1:0];
		frac_c = pos[FRAC_BITS-1:0];
	end

	assign i1_c = (i0_q == LAST_IDX) ? '0 : i0_q + AW'(1);

	// ---------------------------------------------------------------- arithmetic
	always_comb begin
		diff     = $signed({mem_rdata[SB-1], mem_rdata}) - $signed({a_q[SB-1], a_q});
		frac_s   = $signed({1'b0, frac_q});
		mix_prod = diff * frac_s;
		mix      = $signed({{2{a_q[SB-1]}}, a_q, {FRAC_BITS{1'b0}}}) + mix_prod
			+ $signed(MIX_HALF);
	end

	assign gp_c = $signed(y_q) * $signed({1'b0, gain_q});

	always_comb begin
		fb_round = gp_q + GAIN_HALF;
		fb       = $signed(fb_round[ffd_pkg::GAIN_FRAC +: SW]);
		sum      = $signed({{2{x_q[SB-1]}}, x_q}) + fb;
		if (sum[SW-1:SB-1] == {3{1'b0}} || sum[SW-1:SB-1] == {3{1'b1}}) begin
			wb_data = sum[SB-1:0];
		end else if (sum[SW-1]) begin
			wb_data = {1'b1, {(SB-1){1'b0}}};
		end else begin
			wb_data = {1'b0, {(SB-1){1'b1}}};
		end
	end

	// ---------------------------------------------------------------- control
	assign wb_go   = (state_q == ffd_pkg::ST_WB) && (!out_valid_q || !out_stall);
	assign in_take = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffd_pkg::ST_CLEAR: begin
				if (clr_cnt_q == LAST_IDX) begin
					state_d = ffd_pkg::ST_IDLE;
				end
			end
			ffd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ffd_pkg::ST_RD;
				end
			end
			ffd_pkg::ST_RD:  state_d = ffd_pkg::ST_MIX;
			ffd_pkg::ST_MIX: state_d = ffd_pkg::ST_MUL;
			ffd_pkg::ST_MUL: state_d = ffd_pkg::ST_WB;
			ffd_pkg::ST_WB: begin
				if (wb_go) begin
					state_d = in_valid ? ffd_pkg::ST_RD : ffd_pkg::ST_IDLE;
				end
			end
			default: state_d = ffd_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = write_pos_q;
		mem_wdata = wb_data;
		mem_raddr = i0_c;
		case (state_q)
			ffd_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ffd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			ffd_pkg::ST_RD: begin
				mem_raddr = i1_c;
			end
			ffd_pkg::ST_MIX: begin
			end
			ffd_pkg::ST_MUL: begin
			end
			ffd_pkg::ST_WB: begin
				in_stall = !wb_go;
				mem_we   = wb_go;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffd_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			write_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ffd_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (wb_go) begin
				write_pos_q <= wp_inc;
			end
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers; drop out-of-range values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DLY_RESET;
			gain_q  <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				ffd_pkg::REG_DELAY: begin
					if (cfg_data[DLY_W-1:0] != '0 && cfg_data[DLY_W-1:0] <= DLY_MAX) begin
						delay_q <= cfg_data[DLY_W-1:0];
					end
				end
				ffd_pkg::REG_GAIN: begin
					if (cfg_data[ffd_pkg::GAIN_W-1:0] <= ffd_pkg::GAIN_ONE) begin
						gain_q <= cfg_data[ffd_pkg::GAIN_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			i0_q   <= i0_c;
			frac_q <= frac_c;
			x_q    <= sample_in;
		end
		if (state_q == ffd_pkg::ST_RD) begin
			a_q <= $signed(mem_rdata);
		end
		if (state_q == ffd_pkg::ST_MIX) begin
			y_q <= mix[SB+FRAC_BITS-1:FRAC_BITS];
		end
		if (state_q == ffd_pkg::ST_MUL) begin
			gp_q <= gp_c;
		end
		if (wb_go) begin
			sample_out_q <= y_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	ffd_ram #(
		.DEPTH (DEPTH),
		.WIDTH (SB)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------- assertions
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffd_pkg::ST_CLEAR) |-> in_stall)
		else $error("input taken during store clear");

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ffd_pkg::ST_WB))
		else $error("output appeared outside write-back");

	a_wp_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> (write_pos_q != $past(write_pos_q)))
		else $error("write position did not advance");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= ffd_pkg::GAIN_ONE)
		else $error("feedback gain above unity");

	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		(delay_q != '0) && (delay_q <= DLY_MAX))
		else $error("delay register out of range");

endmodule

`default_nettype wire
